### hw/rtl/dqm_pkg.sv
// shared types, command codes and defaults for the deque with pop-maximum
package dqm_pkg;

  // default sizes
  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // command codes
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [2:0] CMD_POP_BACK   = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_POP_MAX    = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // request beat
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] push_value;
  } req_t;

  // response beat
  typedef struct packed {
    logic signed [31:0] result_value;
    logic [1:0]         status;
  } rsp_t;

  // operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD       = 3'd0,
    CELL_PUSH_FRONT = 3'd1,
    CELL_PUSH_BACK  = 3'd2,
    CELL_POP_FRONT  = 3'd3,
    CELL_ROTATE     = 3'd4,
    CELL_CLOSE      = 3'd5
  } cell_op_t;

endpackage

### hw/rtl/deque_with_pop_max.sv
// top level of the bounded deque with pop-maximum, built as a chain of cells
//
// Request channel (req_valid, req_stall, req) carries a command and a push value;
// response channel (rsp_valid, rsp_stall, rsp) returns one beat per request with
// the popped or peeked value and a status (ok, empty, full).
// Entries sit in a chain of DEPTH cells, front entry in cell 0. Pushes, pops and
// peeks finish in the cycle of acceptance: one request per cycle while req_stall is
// low, the response beat appears in the cycle after acceptance.
// Pop maximum rotates the held entries through the chain once, moving one entry
// past the front cell per cycle and comparing the front cell with the running
// best, then closes the gap once the output register is free. req_stall stays
// high meanwhile.
// A stalled response is held in the output register; the next request is still
// taken while the response register drains in the same cycle.
// Reset empties the deque and drops any pending response; cell contents are
// not cleared and are read only after being written.
module deque_with_pop_max #(
  parameter int DEPTH       = dqm_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = dqm_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  dqm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output dqm_pkg::rsp_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_CLOSE = 3'b100
  } state_t;

  state_t                        state, state_next;
  logic [CW-1:0]                 count, count_next;
  logic [IW-1:0]                 scan_pos, scan_pos_next;
  logic [IW-1:0]                 best_idx, best_idx_next;
  logic signed [VALUE_WIDTH-1:0] best_val, best_val_next;
  dqm_pkg::rsp_t                 rsp_next;
  logic                          rsp_load;
  dqm_pkg::cell_op_t             op;
  logic                          accept, out_free, is_full, is_empty;
  logic signed [VALUE_WIDTH-1:0] push_ext;
  logic signed [VALUE_WIDTH-1:0] vals [DEPTH];
  logic signed [VALUE_WIDTH-1:0] back_val;

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dqm_cell #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX         (i)
    ) u_cell (
      .clk      (clk),
      .op       (op),
      .count    (count),
      .best_idx (best_idx),
      .push     (push_ext),
      .prev     ((i == 0) ? push_ext : vals[(i == 0) ? 0 : i - 1]),
      .next     ((i == DEPTH - 1) ? vals[i] : vals[(i == DEPTH - 1) ? i : i + 1]),
      .wrap     (vals[0]),
      .val      (vals[i])
    );
  end

  // handshake and simple derived values
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE) || !out_free;
  assign accept    = req_valid && !req_stall;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign push_ext  = VALUE_WIDTH'(req.push_value);
  assign back_val  = vals[IW'(count - CW'(1))];

  // command sequencing
  always_comb begin
    state_next    = state;
    count_next    = count;
    scan_pos_next = scan_pos;
    best_idx_next = best_idx;
    best_val_next = best_val;
    op            = dqm_pkg::CELL_HOLD;
    rsp_load      = 1'b0;
    rsp_next      = '{result_value: '0, status: dqm_pkg::ST_OK};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rsp_load = 1'b1;
          unique case (req.cmd)
            dqm_pkg::CMD_PUSH_BACK, dqm_pkg::CMD_PUSH_FRONT: begin
              if (is_full) begin
                rsp_next.status = dqm_pkg::ST_FULL;
              end else begin
                op = (req.cmd == dqm_pkg::CMD_PUSH_BACK) ? dqm_pkg::CELL_PUSH_BACK
                                                         : dqm_pkg::CELL_PUSH_FRONT;
                count_next = count + CW'(1);
              end
            end
            dqm_pkg::CMD_POP_BACK, dqm_pkg::CMD_PEEK_BACK: begin
              if (is_empty) begin
                rsp_next.status = dqm_pkg::ST_EMPTY;
              end else begin
                rsp_next.result_value = 32'(back_val);
                if (req.cmd == dqm_pkg::CMD_POP_BACK) count_next = count - CW'(1);
              end
            end
            dqm_pkg::CMD_POP_FRONT, dqm_pkg::CMD_PEEK_FRONT: begin
              if (is_empty) begin
                rsp_next.status = dqm_pkg::ST_EMPTY;
              end else begin
                rsp_next.result_value = 32'(vals[0]);
                if (req.cmd == dqm_pkg::CMD_POP_FRONT) begin
                  op         = dqm_pkg::CELL_POP_FRONT;
                  count_next = count - CW'(1);
                end
              end
            end
            dqm_pkg::CMD_POP_MAX: begin
              if (is_empty) begin
                rsp_next.status = dqm_pkg::ST_EMPTY;
              end else begin
                rsp_load      = 1'b0;
                scan_pos_next = '0;
                state_next    = S_SCAN;
              end
            end
            default: rsp_next.status = dqm_pkg::ST_OK;
          endcase
        end
      end
      S_SCAN: begin
        // front cell holds the entry at scan_pos; rotate it to the back
        op = dqm_pkg::CELL_ROTATE;
        if (scan_pos == '0 || vals[0] > best_val) begin
          best_val_next = vals[0];
          best_idx_next = scan_pos;
        end
        if (CW'(scan_pos) + CW'(1) == count) state_next = S_CLOSE;
        else scan_pos_next = scan_pos + IW'(1);
      end
      S_CLOSE: begin
        // order is restored; drop the best entry once the output is free
        if (out_free) begin
          op                    = dqm_pkg::CELL_CLOSE;
          count_next            = count - CW'(1);
          rsp_load              = 1'b1;
          rsp_next.result_value = 32'(best_val);
          state_next            = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_pos <= scan_pos_next;
    best_idx <= best_idx_next;
    best_val <= best_val_next;
    if (rsp_load) rsp <= rsp_next;
  end

endmodule

### hw/rtl/dqm_cell.sv
// one storage cell of the deque chain, position IDX counted from the front
module dqm_cell #(
  parameter int DEPTH       = dqm_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = dqm_pkg::VALUE_WIDTH_DEF,
  parameter int IDX         = 0,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  dqm_pkg::cell_op_t             op,
  input  logic [CW-1:0]                 count,
  input  logic [IW-1:0]                 best_idx,
  input  logic signed [VALUE_WIDTH-1:0] push,
  input  logic signed [VALUE_WIDTH-1:0] prev,
  input  logic signed [VALUE_WIDTH-1:0] next,
  input  logic signed [VALUE_WIDTH-1:0] wrap,
  output logic signed [VALUE_WIDTH-1:0] val
);

  localparam logic [CW-1:0] MY_POS  = CW'(IDX);
  localparam logic [CW-1:0] MY_POS1 = CW'(IDX + 1);
  localparam logic [IW-1:0] MY_IDX  = IW'(IDX);
  localparam bit            IS_LAST = (IDX == DEPTH - 1);

  logic signed [VALUE_WIDTH-1:0] val_next;

  // pick the new content from the neighbours, the front cell or the pushed value
  always_comb begin
    val_next = val;
    unique case (op)
      dqm_pkg::CELL_PUSH_FRONT: begin
        val_next = (IDX == 0) ? push : prev;
      end
      dqm_pkg::CELL_PUSH_BACK: begin
        if (count == MY_POS) val_next = push;
      end
      dqm_pkg::CELL_POP_FRONT: begin
        if (!IS_LAST) val_next = next;
      end
      dqm_pkg::CELL_ROTATE: begin
        if (MY_POS1 < count) val_next = next;
        else if (MY_POS1 == count) val_next = wrap;
      end
      dqm_pkg::CELL_CLOSE: begin
        if (!IS_LAST && MY_IDX >= best_idx) val_next = next;
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

### test/tb.sv
// self-checking testbench for the deque with pop-maximum
module tb;

  localparam int         DEPTH      = 16;
  localparam int         CYCLE_CAP  = 200000;
  localparam int         RAND_BEATS = 650;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  dqm_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  dqm_pkg::rsp_t rsp;

  deque_with_pop_max uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // clock
  always #5 clk = ~clk;

  // shadow contents, front first, and the responses still owed
  logic signed [31:0] shadow_entries[$];
  dqm_pkg::rsp_t      rsp_due[$];
  dqm_pkg::req_t      req_pending[$];

  int   n_items = 0;
  int   n_taken = 0;
  int   n_beats = 0;
  int   n_err = 0;
  int   n_popmax = 0;
  int   n_full = 0;
  int   n_empty = 0;
  int   cycles = 0;
  logic go = 1'b0;
  logic req_fire = 1'b0;
  logic rsp_fire = 1'b0;
  logic hold_off = 1'b0;
  int   req_gap = 0;
  int   rsp_wait_left = 0;
  int   hold_left = 0;
  int   hold_count = 0;

  // a stretch with no idling on either side
  wire quiet = (n_taken >= 300) && (n_taken < 380);

  // work out the response to one command and update the shadow contents
  function automatic dqm_pkg::rsp_t deque_step(dqm_pkg::req_t r);
    dqm_pkg::rsp_t o;
    int            best;
    o.result_value = '0;
    o.status = dqm_pkg::ST_OK;
    case (r.cmd)
      dqm_pkg::CMD_PUSH_BACK, dqm_pkg::CMD_PUSH_FRONT: begin
        if (shadow_entries.size() >= DEPTH) o.status = dqm_pkg::ST_FULL;
        else if (r.cmd == dqm_pkg::CMD_PUSH_BACK) shadow_entries.push_back(r.push_value);
        else shadow_entries.push_front(r.push_value);
      end
      dqm_pkg::CMD_POP_BACK, dqm_pkg::CMD_POP_FRONT, dqm_pkg::CMD_POP_MAX,
      dqm_pkg::CMD_PEEK_BACK, dqm_pkg::CMD_PEEK_FRONT: begin
        if (shadow_entries.size() == 0) begin
          o.status = dqm_pkg::ST_EMPTY;
        end else begin
          case (r.cmd)
            dqm_pkg::CMD_POP_BACK:   o.result_value = shadow_entries.pop_back();
            dqm_pkg::CMD_POP_FRONT:  o.result_value = shadow_entries.pop_front();
            dqm_pkg::CMD_PEEK_BACK:
              o.result_value = shadow_entries[shadow_entries.size() - 1];
            dqm_pkg::CMD_PEEK_FRONT: o.result_value = shadow_entries[0];
            default: begin
              // first entry from the front holding the largest value
              best = 0;
              for (int i = 1; i < shadow_entries.size(); i++)
                if (shadow_entries[i] > shadow_entries[best]) best = i;
              o.result_value = shadow_entries[best];
              shadow_entries.delete(best);
            end
          endcase
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("beat %0d %s: got %0h, expected %0h", n_beats, what, got, want);
    n_err++;
  endtask

  task automatic add_req(logic [2:0] c, logic [31:0] v);
    dqm_pkg::req_t r;
    r.cmd = c;
    r.push_value = v;
    req_pending.push_back(r);
    n_items++;
  endtask

  // push values: extremes, small values that tie often, and full-range noise
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom_range(0, 6) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_cmd(int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? dqm_pkg::CMD_PUSH_BACK : dqm_pkg::CMD_PUSH_FRONT;
    if ($urandom_range(0, 99) == 0) return CMD_UNUSED;
    return 3'($urandom_range(dqm_pkg::CMD_POP_BACK, dqm_pkg::CMD_PEEK_FRONT));
  endfunction

  // request driver: hold each beat until taken, then wait its drawn gap
  always @(negedge clk) begin
    if (go && !(req_valid && !req_fire)) begin
      if (req_gap != 0) begin
        req_valid <= 1'b0;
        req_gap <= req_gap - 1;
      end else if (req_pending.size() != 0) begin
        req <= req_pending.pop_front();
        req_valid <= 1'b1;
        req_gap <= quiet ? 0 : $urandom_range(0, 4);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // long hold-off on the response side so the block backs up
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_off <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      hold_off <= 1'b0;
      if ((hold_count == 0 && n_taken >= 150) || (hold_count == 1 && n_taken >= 480)) begin
        hold_left <= 60;
        hold_count <= hold_count + 1;
      end
    end
  end

  // response stall: a fresh wait drawn after every beat taken
  always @(negedge clk) begin
    if (rsp_fire) rsp_wait_left = quiet ? 0 : $urandom_range(0, 4);
    if (rsp_wait_left != 0) begin
      rsp_stall <= 1'b1;
      rsp_wait_left = rsp_wait_left - 1;
    end else begin
      rsp_stall <= hold_off;
    end
  end

  // monitor: check the response beat, then predict for the request beat
  always @(posedge clk) begin
    req_fire <= !rst && req_valid && !req_stall;
    rsp_fire <= !rst && rsp_valid && !rsp_stall;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (rsp_due.size() == 0) begin
        report_mismatch("unexpected beat", rsp.result_value, '0);
      end else begin
        dqm_pkg::rsp_t want;
        want = rsp_due.pop_front();
        if (rsp.result_value !== want.result_value)
          report_mismatch("result_value", rsp.result_value, want.result_value);
        if (rsp.status !== want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (want.status == dqm_pkg::ST_FULL) n_full++;
        if (want.status == dqm_pkg::ST_EMPTY) n_empty++;
      end
      n_beats++;
    end
    if (!rst && req_valid && !req_stall) begin
      if (req.cmd == dqm_pkg::CMD_POP_MAX) n_popmax++;
      rsp_due.push_back(deque_step(req));
      n_taken++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout with %0d responses outstanding", rsp_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int push_pct;

    // directed: every pop and peek on an empty store, and the unused code
    add_req(dqm_pkg::CMD_POP_BACK, 32'h1234_5678);
    add_req(dqm_pkg::CMD_POP_FRONT, 32'h0);
    add_req(dqm_pkg::CMD_POP_MAX, 32'hffff_ffff);
    add_req(dqm_pkg::CMD_PEEK_BACK, 32'h0);
    add_req(dqm_pkg::CMD_PEEK_FRONT, 32'h0);
    add_req(CMD_UNUSED, 32'hdead_beef);
    // fill with extremes and tied maxima, then two refused pushes
    for (int i = 0; i < DEPTH; i++) begin
      case (i % 4)
        0:       add_req(dqm_pkg::CMD_PUSH_BACK, 32'h7fff_ffff);
        1:       add_req(dqm_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
        2:       add_req(dqm_pkg::CMD_PUSH_BACK, 32'hffff_ffff);
        default: add_req(dqm_pkg::CMD_PUSH_FRONT, i);
      endcase
    end
    add_req(dqm_pkg::CMD_PUSH_BACK, 32'h5555_5555);
    add_req(dqm_pkg::CMD_PUSH_FRONT, 32'haaaa_aaaa);
    add_req(dqm_pkg::CMD_POP_MAX, 32'h0);
    add_req(dqm_pkg::CMD_POP_MAX, 32'h0);
    add_req(dqm_pkg::CMD_PEEK_BACK, 32'h0);
    add_req(dqm_pkg::CMD_PEEK_FRONT, 32'h0);
    add_req(dqm_pkg::CMD_POP_BACK, 32'h0);
    add_req(dqm_pkg::CMD_POP_FRONT, 32'h0);

    // random phases: filling, draining and balanced mixes
    for (int p = 0; p < RAND_BEATS / 25; p++) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      for (int k = 0; k < 25; k++) add_req(pick_cmd(push_pct), pick_value());
    end

    // reset, then release the driver
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    go <= 1'b1;

    while (n_taken != n_items) @(posedge clk);
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("ran %0d commands: %0d pop-max, %0d refused pushes, %0d empty reads",
             n_taken, n_popmax, n_full, n_empty);
    $display("response side held off %0d times for long stretches", hold_count);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", n_err);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/dqm_pkg.sv
hw/rtl/dqm_cell.sv
hw/rtl/deque_with_pop_max.sv
test/tb.sv
